FILE: sv/tpr_pkg.sv
// Shared constants and field widths for the tinted palette remap block.
// Used by the channel interfaces and by tinted_palette_remap_core.
package tpr_pkg;

  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Transaction codes on the request channel.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_MAP   = 1'b1;

  // Register indexes, decoded from paddr[3:2].
  localparam logic [1:0] REG_TINT_RED     = 2'd0;
  localparam logic [1:0] REG_TINT_GREEN   = 2'd1;
  localparam logic [1:0] REG_TINT_BLUE    = 2'd2;
  localparam logic [1:0] REG_TINT_PERCENT = 2'd3;

  localparam logic [7:0]  PCT_FULL    = 8'd100;
  localparam logic [4:0]  SKIP_DIST   = 5'd21;
  localparam logic [13:0] START_SCORE = 14'd10000;

  // floor(x * 256 / 100) = floor(x * 64 / 25), and n / 25 = (n * 5243) >> 17
  // holds exactly for every n below 6400.
  localparam logic [12:0] RECIP_25 = 13'd5243;

  localparam int MUL_W  = 13;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SCORE_W = 11;

endpackage

FILE: sv/tpr_ifs.sv
// Valid/ready channel interfaces for the palette remap requests and results.
// Depends on tpr_pkg for the field widths.
interface tpr_req_if;
  import tpr_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [INDEX_W-1:0] entry_index;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;

  modport source (output valid, func, entry_index, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, func, entry_index, red_in, green_in, blue_in,
                  output ready);
endinterface

interface tpr_rsp_if;
  import tpr_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] mapped_index;

  modport source (output valid, mapped_index, input ready);
  modport sink   (input valid, mapped_index, output ready);
endinterface

FILE: sv/tinted_palette_remap_core.sv
// Palette remap core: a palette write is stored at the edge that accepts it.
// A map request with percent 0 returns its own entry index; with percent 100
// or more the palette is scanned against the tint, and with a partial blend
// against the tint blended with the indexed entry. The block is ready again
// once the result moves to the output register. The scan reads one entry a
// cycle through the single read port of the palette memory; the blend runs
// nine steps around the one shared multiplier that forms the blend factors
// and the blended color. The request side is not ready while a map request
// is in progress; a result waits in an output register while the next
// transaction is accepted. Depends on tpr_pkg and the interfaces in tpr_ifs.sv.
module tinted_palette_remap_core #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpr_pkg::PADDR_W-1:0]   paddr,
  input  logic [tpr_pkg::PDATA_W-1:0]   pwdata,
  output logic [tpr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  tpr_req_if.sink                       req,
  tpr_rsp_if.source                     rsp
);
  import tpr_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(PALETTE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BLEND = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CHAN_W-1:0] tint_red, tint_green, tint_blue, tint_percent;

  // Palette memory and its registered read port.
  logic [3*CHAN_W-1:0] palette [PALETTE_ENTRIES];
  logic [3*CHAN_W-1:0] rdata;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic                in_range;

  logic req_take;

  // Blend sequencer.
  logic [3:0]        step;
  logic              src_ok;
  logic [CHAN_W-1:0] src_red, src_green, src_blue;
  logic [CHAN_W-1:0] mul_f, scale_f, part;
  logic [CHAN_W-1:0] pct_comp;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  // Search target and scan pipeline.
  logic [CHAN_W-1:0] tgt_red, tgt_green, tgt_blue;
  logic [AW-1:0]     cnt;
  logic              issue_on;
  logic              rd_v;
  logic [AW-1:0]     rd_j;
  logic              d_v;
  logic [AW-1:0]     d_j;
  logic              d_ok;
  logic [4:0]        d_red, d_green, d_blue;
  logic [CHAN_W-1:0] ad_red, ad_green, ad_blue;
  logic [SCORE_W-1:0] score;
  logic              better;
  logic [13:0]       best_s;
  logic [AW-1:0]     best_j;

  logic [INDEX_W-1:0] result;
  logic               out_valid;
  logic [INDEX_W-1:0] out_idx;
  logic               out_load;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint_red     <= '0;
      tint_green   <= '0;
      tint_blue    <= '0;
      tint_percent <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TINT_RED:     tint_red     <= pwdata[CHAN_W-1:0];
        REG_TINT_GREEN:   tint_green   <= pwdata[CHAN_W-1:0];
        REG_TINT_BLUE:    tint_blue    <= pwdata[CHAN_W-1:0];
        REG_TINT_PERCENT: tint_percent <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TINT_RED:     prdata = {{(PDATA_W-CHAN_W){1'b0}}, tint_red};
      REG_TINT_GREEN:   prdata = {{(PDATA_W-CHAN_W){1'b0}}, tint_green};
      REG_TINT_BLUE:    prdata = {{(PDATA_W-CHAN_W){1'b0}}, tint_blue};
      REG_TINT_PERCENT: prdata = {{(PDATA_W-CHAN_W){1'b0}}, tint_percent};
      default:          prdata = '0;
    endcase
  end

  // ---------------- palette memory ----------------
  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;
  assign in_range  = ({1'b0, req.entry_index} < 9'(PALETTE_ENTRIES));
  assign mem_we    = req_take && (req.func == FUNC_WRITE) && in_range;
  assign rd_addr   = (state == S_IDLE) ? req.entry_index[AW-1:0] : cnt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette[req.entry_index[AW-1:0]] <= {req.red_in, req.green_in, req.blue_in};
    end
    rdata <= palette[rd_addr];
  end

  // ---------------- shared multiplier ----------------
  assign pct_comp = PCT_FULL - tint_percent;

  always_comb begin
    case (step)
      4'd0:    begin mul_a = {tint_percent[6:0], 6'b0}; mul_b = RECIP_25; end
      4'd1:    begin mul_a = {pct_comp[6:0], 6'b0};     mul_b = RECIP_25; end
      4'd2:    begin mul_a = MUL_W'(tint_red);   mul_b = MUL_W'(mul_f);   end
      4'd3:    begin mul_a = MUL_W'(src_red);    mul_b = MUL_W'(scale_f); end
      4'd4:    begin mul_a = MUL_W'(tint_green); mul_b = MUL_W'(mul_f);   end
      4'd5:    begin mul_a = MUL_W'(src_green);  mul_b = MUL_W'(scale_f); end
      4'd6:    begin mul_a = MUL_W'(tint_blue);  mul_b = MUL_W'(mul_f);   end
      4'd7:    begin mul_a = MUL_W'(src_blue);   mul_b = MUL_W'(scale_f); end
      default: begin mul_a = '0;                 mul_b = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- scan datapath ----------------
  always_comb begin
    ad_red   = (rdata[23:16] > tgt_red)   ? rdata[23:16] - tgt_red   : tgt_red   - rdata[23:16];
    ad_green = (rdata[15:8]  > tgt_green) ? rdata[15:8]  - tgt_green : tgt_green - rdata[15:8];
    ad_blue  = (rdata[7:0]   > tgt_blue)  ? rdata[7:0]   - tgt_blue  : tgt_blue  - rdata[7:0];
  end

  assign score  = SCORE_W'(d_red) * SCORE_W'(d_red) + SCORE_W'(d_green) * SCORE_W'(d_green)
                + SCORE_W'(d_blue) * SCORE_W'(d_blue);
  assign better = d_v && d_ok && ({3'b0, score} < best_s);

  always_ff @(posedge clk) begin
    d_ok    <= (ad_red < 8'(SKIP_DIST)) && (ad_green < 8'(SKIP_DIST))
            && (ad_blue < 8'(SKIP_DIST));
    d_red   <= ad_red[4:0];
    d_green <= ad_green[4:0];
    d_blue  <= ad_blue[4:0];
    d_j     <= rd_j;
    rd_j    <= cnt;
    if (better) begin
      best_s <= {3'b0, score};
      best_j <= d_j;
    end
    if (state == S_IDLE || state == S_BLEND) begin
      best_s <= START_SCORE;
      best_j <= '0;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      issue_on <= 1'b0;
      rd_v     <= 1'b0;
      d_v      <= 1'b0;
      cnt      <= '0;
    end else begin
      rd_v <= issue_on;
      d_v  <= rd_v;
      case (state)
        S_IDLE: begin
          if (req_take && req.func == FUNC_MAP) begin
            src_ok <= in_range;
            step   <= '0;
            cnt    <= '0;
            if (tint_percent == '0) begin
              result <= req.entry_index;
              state  <= S_DONE;
            end else if (tint_percent >= PCT_FULL) begin
              tgt_red   <= tint_red;
              tgt_green <= tint_green;
              tgt_blue  <= tint_blue;
              issue_on  <= 1'b1;
              state     <= S_SCAN;
            end else begin
              state <= S_BLEND;
            end
          end
        end
        S_BLEND: begin
          step <= step + 4'd1;
          // Product k is consumed in the step after it is issued, from the registered prod.
          case (step)
            4'd0: begin
              src_red   <= src_ok ? rdata[23:16] : '0;
              src_green <= src_ok ? rdata[15:8]  : '0;
              src_blue  <= src_ok ? rdata[7:0]   : '0;
            end
            4'd1: mul_f     <= prod[24:17];
            4'd2: scale_f   <= prod[24:17];
            4'd3: part      <= prod[15:8];
            4'd4: tgt_red   <= part + prod[15:8];
            4'd5: part      <= prod[15:8];
            4'd6: tgt_green <= part + prod[15:8];
            4'd7: part      <= prod[15:8];
            4'd8: begin
              tgt_blue <= part + prod[15:8];
              issue_on <= 1'b1;
              state    <= S_SCAN;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (issue_on) begin
            if (cnt == LAST_ENTRY) begin
              issue_on <= 1'b0;
            end else begin
              cnt <= cnt + AW'(1);
            end
          end
          if (d_v && d_j == LAST_ENTRY) begin
            result <= INDEX_W'(better ? d_j : best_j);
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_idx <= result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.mapped_index = out_idx;

  // ---------------- assertions ----------------
  // The scan pipeline has drained by the time a result is ready to leave.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> !rd_v && !d_v && !issue_on)
    else $error("scan pipeline not empty at result");

  // Entries reach the score stage in strictly ascending order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    d_v |=> (!d_v || d_j == $past(d_j) + AW'(1)))
    else $error("scan entries out of order");

  // A qualifying candidate never scores above three times the square of one less than the skip limit.
  a_score: assert property (@(posedge clk) disable iff (rst)
    d_v && d_ok |-> score <= SCORE_W'(1200))
    else $error("qualified score out of range");

  // The blend sequencer never runs past its last step.
  a_step: assert property (@(posedge clk) disable iff (rst)
    state == S_BLEND |-> step <= 4'd8)
    else $error("blend step overrun");

  // No new request is taken while a result is still being formed.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_BLEND) |-> !req.ready)
    else $error("request accepted while busy");

endmodule
